// ===== sv/svlp_pkg.sv =====
// shared types and constants of the schema lexical value parser
package svlp_pkg;

    // configured value types
    localparam logic [2:0] TYPE_ANY    = 3'd0;
    localparam logic [2:0] TYPE_DEC    = 3'd1;
    localparam logic [2:0] TYPE_DATE   = 3'd2;
    localparam logic [2:0] TYPE_POS    = 3'd3;
    localparam logic [2:0] TYPE_NONNEG = 3'd4;

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_INT   = 4'd1,
        PH_FRAC  = 4'd2,
        PH_MON1  = 4'd3,
        PH_MON2  = 4'd4,
        PH_DASH2 = 4'd5,
        PH_DAY1  = 4'd6,
        PH_DAY2  = 4'd7,
        PH_DONE  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_value;
    } in_t;

    typedef struct packed {
        logic        valid_res;
        logic [63:0] magnitude;
        logic        negative;
        logic [7:0]  frac_digits;
        logic [7:0]  total_digits;
    } out_t;

    typedef struct packed {
        phase_t      phase;
        logic [63:0] accum;
        logic [7:0]  int_count;
        logic [7:0]  frac_count;
        logic        neg_seen;
        logic        failed;
        logic [7:0]  held_char;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        phase:      PH_START,
        accum:      64'd0,
        int_count:  8'd0,
        frac_count: 8'd0,
        neg_seen:   1'b0,
        failed:     1'b0,
        held_char:  8'd0
    };

    function automatic logic [7:0] sat_inc(input logic [7:0] n);
        sat_inc = (n == COUNT_MAX) ? n : n + 8'd1;
    endfunction

endpackage

// ===== sv/svlp_step.sv =====
// per-item update of the parse state and the verdict at the end of a value
module svlp_step (
    input  logic [2:0]       value_type,
    input  svlp_pkg::state_t state,
    input  svlp_pkg::in_t    item,
    output svlp_pkg::state_t state_next,
    output svlp_pkg::out_t   result
);

    logic [7:0]  c;
    logic        digit;
    logic [3:0]  dval;
    logic [63:0] acc10;
    logic        is_dec;
    logic        is_num;
    logic        minus_ok;
    logic        ok;
    logic [8:0]  tot;

    assign c        = item.ch;
    assign digit    = (c >= svlp_pkg::CH_0) && (c <= svlp_pkg::CH_9);
    assign dval     = c[3:0];
    // accum * 10 + digit as two shifted terms
    assign acc10    = {state.accum[60:0], 3'b000} + {state.accum[62:0], 1'b0}
                    + {60'd0, dval};
    assign is_dec   = (value_type == svlp_pkg::TYPE_DEC);
    assign is_num   = is_dec || (value_type == svlp_pkg::TYPE_POS)
                    || (value_type == svlp_pkg::TYPE_NONNEG);
    assign minus_ok = is_dec || (value_type == svlp_pkg::TYPE_NONNEG);
    assign tot      = {1'b0, state.int_count} + {1'b0, state.frac_count};

    always_comb
    begin
        state_next = state;
        if (item.end_of_value)
        begin
            state_next = svlp_pkg::STATE_CLEAR;
        end
        else if (!state.failed && is_num)
        begin
            if (digit && (state.phase == svlp_pkg::PH_START
                          || state.phase == svlp_pkg::PH_INT
                          || state.phase == svlp_pkg::PH_FRAC))
            begin
                state_next.accum = acc10;
                if (state.phase == svlp_pkg::PH_FRAC)
                    state_next.frac_count = svlp_pkg::sat_inc(state.frac_count);
                else
                    state_next.int_count = svlp_pkg::sat_inc(state.int_count);
                if (state.phase == svlp_pkg::PH_START)
                    state_next.phase = svlp_pkg::PH_INT;
            end
            else if (state.phase == svlp_pkg::PH_START
                     && (c == svlp_pkg::CH_PLUS || (c == svlp_pkg::CH_MINUS && minus_ok)))
            begin
                state_next.neg_seen = (c == svlp_pkg::CH_MINUS);
                state_next.phase    = svlp_pkg::PH_INT;
            end
            else if (is_dec && c == svlp_pkg::CH_POINT
                     && (state.phase == svlp_pkg::PH_START
                         || state.phase == svlp_pkg::PH_INT))
            begin
                state_next.phase = svlp_pkg::PH_FRAC;
            end
            else
            begin
                state_next.failed = 1'b1;
            end
        end
        else if (!state.failed && value_type == svlp_pkg::TYPE_DATE)
        begin
            unique case (state.phase)
                svlp_pkg::PH_START:
                begin
                    if (c == svlp_pkg::CH_MINUS)
                        state_next.phase = svlp_pkg::PH_INT;
                    else if (digit)
                    begin
                        state_next.int_count = svlp_pkg::sat_inc(state.int_count);
                        state_next.phase     = svlp_pkg::PH_INT;
                    end
                    else
                        state_next.failed = 1'b1;
                end
                svlp_pkg::PH_INT:
                begin
                    if (digit)
                        state_next.int_count = svlp_pkg::sat_inc(state.int_count);
                    else if (c == svlp_pkg::CH_MINUS && state.int_count >= 8'd4)
                        state_next.phase = svlp_pkg::PH_MON1;
                    else
                        state_next.failed = 1'b1;
                end
                svlp_pkg::PH_MON1:
                begin
                    if (c == svlp_pkg::CH_0 || c == svlp_pkg::CH_1)
                    begin
                        state_next.held_char = c;
                        state_next.phase     = svlp_pkg::PH_MON2;
                    end
                    else
                        state_next.failed = 1'b1;
                end
                svlp_pkg::PH_MON2:
                begin
                    // month 00 and 13..19 rejected
                    if (!digit || (state.held_char == svlp_pkg::CH_0 && c == svlp_pkg::CH_0)
                        || (state.held_char == svlp_pkg::CH_1 && c > svlp_pkg::CH_2))
                        state_next.failed = 1'b1;
                    else
                        state_next.phase = svlp_pkg::PH_DASH2;
                end
                svlp_pkg::PH_DASH2:
                begin
                    if (c == svlp_pkg::CH_MINUS)
                        state_next.phase = svlp_pkg::PH_DAY1;
                    else
                        state_next.failed = 1'b1;
                end
                svlp_pkg::PH_DAY1:
                begin
                    if (c >= svlp_pkg::CH_0 && c <= svlp_pkg::CH_3)
                    begin
                        state_next.held_char = c;
                        state_next.phase     = svlp_pkg::PH_DAY2;
                    end
                    else
                        state_next.failed = 1'b1;
                end
                svlp_pkg::PH_DAY2:
                begin
                    // day 00 and 32..39 rejected
                    if (!digit || (state.held_char == svlp_pkg::CH_0 && c == svlp_pkg::CH_0)
                        || (state.held_char == svlp_pkg::CH_3 && c > svlp_pkg::CH_1))
                        state_next.failed = 1'b1;
                    else
                        state_next.phase = svlp_pkg::PH_DONE;
                end
                default:
                begin
                    state_next.failed = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        ok = !state.failed;
        if (value_type == svlp_pkg::TYPE_DATE && state.phase != svlp_pkg::PH_DONE)
            ok = 1'b0;
        if (value_type == svlp_pkg::TYPE_NONNEG && state.neg_seen && state.accum != 64'd0)
            ok = 1'b0;

        result              = '0;
        result.valid_res    = ok;
        if (ok && is_num)
        begin
            result.magnitude    = state.accum;
            result.total_digits = tot[8] ? svlp_pkg::COUNT_MAX : tot[7:0];
            if (is_dec)
            begin
                result.negative    = state.neg_seen;
                result.frac_digits = state.frac_count;
            end
        end
    end

endmodule

// ===== sv/schema_lexical_value_parser_core.sv =====
// an item accepted into the input register is processed from there; an end item loads
//   a verdict into the result register, which drives out_valid, once that register is free
// throughput: one character item per cycle except while an end item waits on a full result
//   register; set by the single multiply-by-ten add and phase update between the two registers
// reset: rst_n clears the value type to any string, the partial value and both
//   valid flags at once
module schema_lexical_value_parser_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_wr_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  svlp_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output svlp_pkg::out_t out_data
);

    logic             in_vld_reg;
    logic             in_vld_next;
    svlp_pkg::in_t    in_reg;
    logic             res_vld_reg;
    logic             res_vld_next;
    svlp_pkg::out_t   res_reg;
    svlp_pkg::state_t state_reg;
    svlp_pkg::state_t state_next;
    svlp_pkg::state_t step_state;
    svlp_pkg::out_t   step_result;
    logic [2:0]       type_reg;
    logic             proceed;

    svlp_step u_step (
        .value_type (type_reg),
        .state      (state_reg),
        .item       (in_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    // an end item waits only while the result register is full and not taken
    assign proceed  = in_vld_reg && (!in_reg.end_of_value || !res_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || proceed;

    always_comb
    begin
        in_vld_next  = in_ready ? in_valid : in_vld_reg;
        res_vld_next = (proceed && in_reg.end_of_value) ? 1'b1
                     : (out_ready ? 1'b0 : res_vld_reg);
        state_next   = state_reg;
        if (cfg_wr_en)
            state_next = svlp_pkg::STATE_CLEAR;
        else if (proceed)
            state_next = step_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            state_reg   <= svlp_pkg::STATE_CLEAR;
            type_reg    <= svlp_pkg::TYPE_ANY;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
            state_reg   <= state_next;
            if (cfg_wr_en)
                type_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
        if (proceed && in_reg.end_of_value)
            res_reg <= step_result;
    end

    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

endmodule

// ===== sv/svlp_checker.sv =====
// port-level checker for the schema lexical value parser, bound to the top level
module svlp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cfg_wr_en,
    input logic [2:0]     cfg_wr_data,
    input logic           in_valid,
    input logic           in_ready,
    input svlp_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input svlp_pkg::out_t out_data
);

    // a waiting verdict stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("verdict withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("verdict changed while stalled");

    // a rejected value carries no number
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |-> out_data.magnitude == 64'd0
        && !out_data.negative && out_data.frac_digits == 8'd0
        && out_data.total_digits == 8'd0)
        else $error("invalid verdict with non-zero fields");

    a_digit_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.frac_digits <= out_data.total_digits)
        else $error("fraction digits exceed total digits");

    // input back-pressure only comes from an unread verdict
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting verdict");

endmodule

bind schema_lexical_value_parser_core svlp_checker u_svlp_checker (.*);
